// ===== design/pee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types, codes and sizes of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_BADEXP   = 3'd3;
  localparam logic [2:0] ST_BADTOKEN = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_EXTRA    = 3'd6;
  localparam logic [2:0] ST_OVERFLOW = 3'd7;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_POW = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } mdu_req_t;

endpackage

// ===== design/pee_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pee_mdu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply, divide and power unit
// One 32-bit multiplier and one restoring divider step, used iteratively.
// ----------------------------------------------------------------------------
module pee_mdu (
  input  logic              clk,
  input  logic              rst_n,
  input  pee_pkg::mdu_req_t req,
  output logic              done,
  output logic [31:0]       result
);

  import pee_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_DIV  = 3'd2;
  localparam logic [2:0] M_POW  = 3'd3;
  localparam logic [2:0] M_FIX  = 3'd4;

  logic [2:0]  mst_r, mst_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] mul_lhs;
  logic [31:0] prod;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign mul_lhs = (mst_r == M_POW && phase_r) ? base_r : acc_r;
  assign prod    = mul_lhs * base_r;
  assign shifted = {rem_r, quo_r[31]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    mst_nxt   = mst_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (mst_r)
      M_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL: begin
              acc_nxt  = req.a;
              base_nxt = req.b;
              mst_nxt  = M_MUL;
            end
            OP_DIV: begin
              quo_nxt = req.a[31] ? 32'd0 - req.a : req.a;
              dvs_nxt = req.b[31] ? 32'd0 - req.b : req.b;
              rem_nxt = '0;
              neg_nxt = req.a[31] ^ req.b[31];
              cnt_nxt = '0;
              mst_nxt = M_DIV;
            end
            default: begin
              acc_nxt   = 32'd1;
              base_nxt  = req.a;
              exp_nxt   = req.b;
              phase_nxt = 1'b0;
              mst_nxt   = M_POW;
            end
          endcase
        end
      end
      M_MUL: begin
        res_nxt  = prod;
        done_nxt = 1'b1;
        mst_nxt  = M_IDLE;
      end
      M_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = shifted[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          mst_nxt = M_FIX;
        end
      end
      M_FIX: begin
        res_nxt  = neg_r ? 32'd0 - quo_r : quo_r;
        done_nxt = 1'b1;
        mst_nxt  = M_IDLE;
      end
      M_POW: begin
        if (exp_r == 32'd0) begin
          res_nxt  = acc_r;
          done_nxt = 1'b1;
          mst_nxt  = M_IDLE;
        end else if (!phase_r) begin
          if (exp_r[0]) begin
            acc_nxt = prod;
          end
          phase_nxt = 1'b1;
        end else begin
          base_nxt  = prod;
          exp_nxt   = {1'b0, exp_r[31:1]};
          phase_nxt = 1'b0;
        end
      end
      default: begin
        mst_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mst_r  <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      mst_r  <= mst_nxt;
      done_r <= done_nxt;
    end
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    exp_r   <= exp_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== design/postfix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Digits, spaces, tabs and newlines stay in S_IDLE; an end transfer passes S_END
// and S_END2 before its result is registered. + and - pass S_OP, S_RD1 and S_RD2;
// *, / and ^ also wait in S_RUN (one quotient bit per cycle in the divider, two
// multiplier passes per exponent bit). The input is not ready while an item works.
// Reset clears the sequencer, the stack count, the number and the error state.
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates an RPN expression one character at a time over an operand stack.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pee_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pee_pkg::out_t out_data
);

  import pee_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;
  localparam logic [2:0] S_END2 = 3'd6;

  logic [2:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             rd_r, rd_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [7:0]       opc_r, opc_nxt;
  logic [31:0]      rgt_r, rgt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rdata;
  mdu_req_t          req;
  logic              mdu_done;
  logic [31:0]       mdu_res;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [31:0]      acc10;
  logic             full;
  logic [7:0]       digit;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);
  assign full   = (cnt_r >= CNT_W'(STACK_DEPTH));
  assign digit  = in_data.symbol - CH_0;
  assign acc10  = (acc_r << 3) + (acc_r << 1) + {24'd0, digit};

  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    rd_nxt        = rd_r;
    err_nxt       = err_r;
    opc_nxt       = opc_r;
    rgt_nxt       = rgt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = cnt_r[ADDR_W-1:0];
    wdata         = acc_r;
    raddr         = '0;
    req           = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.mode) begin
            if (err_r == ST_OK && rd_r) begin
              if (full) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            st_nxt = S_END;
          end else if (err_r == ST_OK) begin
            if (in_data.symbol inside {[CH_0:CH_9]}) begin
              acc_nxt = acc10;
              rd_nxt  = 1'b1;
            end else if (in_data.symbol inside {CH_SPACE, CH_TAB, CH_PLUS, CH_MINUS,
                                                CH_STAR, CH_SLASH, CH_CARET}) begin
              if (rd_r) begin
                if (full) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  we      = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
              end
              acc_nxt = '0;
              rd_nxt  = 1'b0;
              if (!(in_data.symbol inside {CH_SPACE, CH_TAB})) begin
                opc_nxt = in_data.symbol;
                st_nxt  = S_OP;
              end
            end else if (in_data.symbol != CH_NL) begin
              err_nxt = ST_BADTOKEN;
            end
          end
        end
      end
      S_OP: begin
        if (err_r != ST_OK) begin
          st_nxt = S_IDLE;
        end else if (cnt_r < CNT_W'(2)) begin
          err_nxt = ST_UNDERFLOW;
          st_nxt  = S_IDLE;
        end else begin
          raddr  = cnt_m1[ADDR_W-1:0];
          st_nxt = S_RD1;
        end
      end
      S_RD1: begin
        raddr   = cnt_m2[ADDR_W-1:0];
        rgt_nxt = rdata;
        st_nxt  = S_RD2;
      end
      S_RD2: begin
        cnt_nxt = cnt_m2;
        waddr   = cnt_m2[ADDR_W-1:0];
        req.a   = rdata;
        req.b   = rgt_r;
        st_nxt  = S_IDLE;
        case (opc_r)
          CH_PLUS: begin
            we      = 1'b1;
            wdata   = rdata + rgt_r;
            cnt_nxt = cnt_m1;
          end
          CH_MINUS: begin
            we      = 1'b1;
            wdata   = rdata - rgt_r;
            cnt_nxt = cnt_m1;
          end
          CH_STAR: begin
            req.start = 1'b1;
            req.op    = OP_MUL;
            st_nxt    = S_RUN;
          end
          CH_SLASH: begin
            if (rgt_r == 32'd0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              req.start = 1'b1;
              req.op    = OP_DIV;
              st_nxt    = S_RUN;
            end
          end
          default: begin
            if (rgt_r[31]) begin
              err_nxt = ST_BADEXP;
            end else begin
              req.start = 1'b1;
              req.op    = OP_POW;
              st_nxt    = S_RUN;
            end
          end
        endcase
      end
      S_RUN: begin
        if (mdu_done) begin
          if (full) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            wdata   = mdu_res;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          st_nxt = S_IDLE;
        end
      end
      S_END: begin
        raddr  = '0;
        st_nxt = S_END2;
      end
      S_END2: begin
        out_nxt.value = '0;
        if (err_r != ST_OK) begin
          out_nxt.status = err_r;
        end else if (cnt_r == '0) begin
          out_nxt.status = ST_EMPTY;
        end else if (cnt_r > CNT_W'(1)) begin
          out_nxt.status = ST_EXTRA;
        end else begin
          out_nxt.status = ST_OK;
          out_nxt.value  = rdata;
        end
        out_valid_nxt = 1'b1;
        cnt_nxt       = '0;
        acc_nxt       = '0;
        rd_nxt        = 1'b0;
        err_nxt       = ST_OK;
        st_nxt        = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      rd_r        <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      rd_r        <= rd_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opc_r <= opc_nxt;
    rgt_r <= rgt_nxt;
    out_r <= out_nxt;
  end

  pee_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  pee_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (mdu_done),
    .result(mdu_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
